// ===== hw/rtl/hcs_pkg.sv =====
`default_nettype none
package hcs_pkg;

  localparam int BITS_W = 28;
  localparam int COUNT_W = 21;
  localparam int DIST_W = 9;
  localparam logic [BITS_W-1:0] BITS_MAX = {BITS_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } hcs_in_t;

  typedef struct packed {
    logic [BITS_W-1:0]  compressed_bits;
    logic [COUNT_W-1:0] byte_count;
    logic [DIST_W-1:0]  distinct_symbols;
  } hcs_out_t;

  // build result handed to the output stage
  typedef struct packed {
    logic              emit;
    logic [BITS_W-1:0] bits;
    logic [DIST_W-1:0] distinct;
  } hcs_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hcs_hist.sv =====
`default_nettype none
module hcs_hist import hcs_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int CNT_W = 21
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             inc_vld,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] inc_sym,
  input  wire logic                             scan_mode,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] scan_addr,
  input  wire logic                             clr,
  output logic      [CNT_W-1:0]                 scan_data
);

  localparam int SYM_W = $clog2(ALPHABET_SIZE);

  logic [CNT_W-1:0] mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vbit_r;
  logic [CNT_W-1:0] rd_r;
  logic rdv_r;
  logic [SYM_W-1:0] raddr;
  logic s1_vld_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic w_vld_r;
  logic [SYM_W-1:0] w_addr_r;
  logic [CNT_W-1:0] w_data_r;
  logic [CNT_W-1:0] old_val;
  logic [CNT_W-1:0] new_val;

  assign raddr = scan_mode ? scan_addr : inc_sym;

  // forward the write made at the same edge as this entry's read
  always_comb begin
    if (w_vld_r && (w_addr_r == s1_sym_r)) begin
      old_val = w_data_r;
    end else begin
      old_val = rdv_r ? rd_r : '0;
    end
    new_val = old_val + CNT_W'(1);
  end

  assign scan_data = rdv_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
    rdv_r <= vbit_r[raddr];
    if (s1_vld_r) begin
      mem[s1_sym_r] <= new_val;
    end
    s1_sym_r <= inc_sym;
    w_addr_r <= s1_sym_r;
    w_data_r <= new_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vbit_r <= '0;
      s1_vld_r <= 1'b0;
      w_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= inc_vld;
      w_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        vbit_r[s1_sym_r] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hcs_build.sv =====
`default_nettype none
module hcs_build import hcs_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int CNT_W = 21
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             out_free,
  input  wire logic [CNT_W-1:0]                 hist_data,
  output logic                                  scan_mode,
  output logic      [$clog2(ALPHABET_SIZE)-1:0] scan_addr,
  output hcs_res_t                              res
);

  localparam int SYM_W = $clog2(ALPHABET_SIZE);
  localparam int NC_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_WA = 3'd3;
  localparam logic [2:0] S_WB = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [CNT_W-1:0] node_mem [ALPHABET_SIZE];
  logic [CNT_W-1:0] node_rd_r;
  logic [2:0] st_r, st_nxt;
  logic [NC_W-1:0] ki_r, ki_nxt;
  logic [NC_W-1:0] n_r, n_nxt;
  logic pv_r, pv_nxt;
  logic [NC_W-1:0] pidx_r, pidx_nxt;
  logic av_r, av_nxt, bv_r, bv_nxt;
  logic [SYM_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [CNT_W-1:0] wta_r, wta_nxt, wtb_r, wtb_nxt;
  logic [CNT_W-1:0] lastv_r, lastv_nxt;
  logic [CNT_W-1:0] merged_r, merged_nxt;
  logic [BITS_W-1:0] total_r, total_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic we;
  logic [SYM_W-1:0] waddr;
  logic [CNT_W-1:0] wdata;
  logic [SYM_W-1:0] raddr;
  logic [31:0] tsum;
  logic [CNT_W-1:0] cur;

  always_ff @(posedge clk) begin
    node_rd_r <= node_mem[raddr];
    if (we) begin
      node_mem[waddr] <= wdata;
    end
  end

  always_comb begin
    st_nxt = st_r;
    ki_nxt = ki_r;
    n_nxt = n_r;
    pv_nxt = 1'b0;
    pidx_nxt = ki_r;
    av_nxt = av_r;
    bv_nxt = bv_r;
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    wta_nxt = wta_r;
    wtb_nxt = wtb_r;
    lastv_nxt = lastv_r;
    merged_nxt = merged_r;
    total_nxt = total_r;
    dist_nxt = dist_r;
    we = 1'b0;
    waddr = n_r[SYM_W-1:0];
    wdata = hist_data;
    raddr = ki_r[SYM_W-1:0];
    scan_mode = 1'b0;
    scan_addr = ki_r[SYM_W-1:0];
    res.emit = 1'b0;
    res.bits = total_r;
    res.distinct = dist_r;
    cur = node_rd_r;
    tsum = 32'(total_r) + 32'(merged_r);
    case (st_r)
      S_IDLE: begin
        if (start) begin
          st_nxt = S_SCAN;
          ki_nxt = '0;
          n_nxt = '0;
          total_nxt = '0;
        end
      end
      S_SCAN: begin
        scan_mode = 1'b1;
        if (ki_r < NC_W'(ALPHABET_SIZE)) begin
          ki_nxt = ki_r + NC_W'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          if (hist_data != '0) begin
            we = 1'b1;
            n_nxt = n_r + NC_W'(1);
          end
          if (pidx_r == NC_W'(ALPHABET_SIZE - 1)) begin
            dist_nxt = DIST_W'(n_nxt);
            ki_nxt = '0;
            pv_nxt = 1'b0;
            av_nxt = 1'b0;
            bv_nxt = 1'b0;
            st_nxt = (n_nxt > NC_W'(1)) ? S_FIND : S_EMIT;
          end
        end
      end
      S_FIND: begin
        if (ki_r < n_r) begin
          ki_nxt = ki_r + NC_W'(1);
          pv_nxt = 1'b1;
        end
        if (pv_r) begin
          if (!av_r || (cur < wta_r)) begin
            ib_nxt = ia_r;
            wtb_nxt = wta_r;
            bv_nxt = av_r;
            ia_nxt = pidx_r[SYM_W-1:0];
            wta_nxt = cur;
            av_nxt = 1'b1;
          end else if (!bv_r || (cur < wtb_r)) begin
            ib_nxt = pidx_r[SYM_W-1:0];
            wtb_nxt = cur;
            bv_nxt = 1'b1;
          end
          if (pidx_r == n_r - NC_W'(1)) begin
            lastv_nxt = cur;
            pv_nxt = 1'b0;
            st_nxt = S_WA;
          end
        end
      end
      S_WA: begin
        merged_nxt = CNT_W'((CNT_W + 1)'(wta_r) + (CNT_W + 1)'(wtb_r));
        we = 1'b1;
        waddr = ia_r;
        wdata = merged_nxt;
        st_nxt = S_WB;
      end
      S_WB: begin
        we = 1'b1;
        waddr = ib_r;
        wdata = (NC_W'(ia_r) == n_r - NC_W'(1)) ? merged_r : lastv_r;
        total_nxt = (tsum > 32'(BITS_MAX)) ? BITS_MAX : BITS_W'(tsum);
        n_nxt = n_r - NC_W'(1);
        ki_nxt = '0;
        av_nxt = 1'b0;
        bv_nxt = 1'b0;
        st_nxt = (n_nxt > NC_W'(1)) ? S_FIND : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          res.emit = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pv_r <= 1'b0;
      av_r <= 1'b0;
      bv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pv_r <= pv_nxt;
      av_r <= av_nxt;
      bv_r <= bv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ki_r <= ki_nxt;
    n_r <= n_nxt;
    pidx_r <= pidx_nxt;
    ia_r <= ia_nxt;
    ib_r <= ib_nxt;
    wta_r <= wta_nxt;
    wtb_r <= wtb_nxt;
    lastv_r <= lastv_nxt;
    merged_r <= merged_nxt;
    total_r <= total_nxt;
    dist_r <= dist_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/huffman_compressed_size_core.sv =====
// channel   signals                          request
// in        in_valid, in_ready, in_data      one byte, last flag
// out       out_valid, out_ready, out_data   bit total, byte count, distinct symbols
//
// bytes are taken one per cycle; the histogram update is a read-modify-write
// with one-deep forwarding. after last, the build scans all ALPHABET_SIZE histogram
// entries, then per merge finds the two smallest live nodes and writes back the merged one.
// in_ready is low from the last byte until the result is loaded into the output
// register. reset clears control state; the histogram clears through valid bits.
`default_nettype none
module huffman_compressed_size_core import hcs_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = 1048576,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hcs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hcs_out_t      out_data
);

  localparam int SYM_W = $clog2(ALPHABET_SIZE);
  localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);

  logic busy_r, busy_nxt;
  logic start_r;
  logic [CNT_W-1:0] cnt_r;
  logic in_acc;
  logic counted;
  logic scan_mode;
  logic [SYM_W-1:0] scan_addr;
  logic [CNT_W-1:0] hist_data;
  hcs_res_t res;
  logic out_free;
  logic out_vld_r;
  hcs_out_t out_r;

  assign in_ready = !busy_r;
  assign in_acc = in_valid && in_ready;
  assign counted = in_acc && (9'(in_data.data_byte) < 9'(ALPHABET_SIZE))
                   && (cnt_r < CNT_W'(MAX_BLOCK_BYTES));
  assign out_free = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data = out_r;

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc && in_data.last) begin
      busy_nxt = 1'b1;
    end else if (res.emit) begin
      busy_nxt = 1'b0;
    end
  end

  hcs_hist #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .CNT_W(CNT_W)
  ) u_hist (
    .clk(clk),
    .rst_n(rst_n),
    .inc_vld(counted),
    .inc_sym(in_data.data_byte[SYM_W-1:0]),
    .scan_mode(scan_mode),
    .scan_addr(scan_addr),
    .clr(res.emit),
    .scan_data(hist_data)
  );

  hcs_build #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .CNT_W(CNT_W)
  ) u_build (
    .clk(clk),
    .rst_n(rst_n),
    .start(start_r),
    .out_free(out_free),
    .hist_data(hist_data),
    .scan_mode(scan_mode),
    .scan_addr(scan_addr),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      start_r <= 1'b0;
      cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      start_r <= in_acc && in_data.last;
      if (res.emit) begin
        cnt_r <= '0;
      end else if (counted) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (res.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_r.compressed_bits <= res.bits;
      out_r.byte_count <= (32'(cnt_r) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt_r);
      out_r.distinct_symbols <= res.distinct;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hcs_checker.sv =====
`default_nettype none
module hcs_checker import hcs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire hcs_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire hcs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed under stall");

  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.distinct_symbols <= DIST_W'(1)) |->
      (out_data.compressed_bits == '0))
    else $error("nonzero bits with at most one symbol");

  a_count_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.byte_count) >= 32'(out_data.distinct_symbols)))
    else $error("fewer bytes than distinct symbols");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("in_ready high right after last request");

endmodule

bind huffman_compressed_size_core hcs_checker u_hcs_checker (.*);
`default_nettype wire
